// ===== sv/dual_wheel_speed_estimator_assert.svh =====
// assertion macros for the dual wheel speed estimator
// used inside module bodies that have clk and arst_n in scope
`ifndef DUAL_WHEEL_SPEED_ESTIMATOR_ASSERT_SVH
`define DUAL_WHEEL_SPEED_ESTIMATOR_ASSERT_SVH
`ifndef SYNTH
`define DWSE_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error(msg);
`define DWSE_ASSERT_NEXT(lbl, ante, cons, msg) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DWSE_ASSERT(lbl, prop, msg)
`define DWSE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/dwse_pkg.sv =====
// types and constants of the dual wheel speed estimator
// no dependencies
`default_nettype none
package dwse_pkg;

	localparam logic [15:0] SPEED_MAX   = 16'hFFFF;
	localparam int unsigned TICK_STEP   = 100;
	localparam int unsigned SPEED_SCALE = 360;
	localparam logic [15:0] SLOW_RESET  = 16'd20000;
	localparam logic [15:0] FAST_RESET  = 16'd1;

	// numerator is 360 * circumference, denominator is period * poles
	localparam int NUM_BITS = 25;
	localparam int DEN_BITS = 24;
	localparam int CNT_BITS = $clog2(NUM_BITS);

	localparam logic [2:0] CFG_FRONT_POLES = 3'd0;
	localparam logic [2:0] CFG_FRONT_CIRC  = 3'd1;
	localparam logic [2:0] CFG_REAR_POLES  = 3'd2;
	localparam logic [2:0] CFG_REAR_CIRC   = 3'd3;
	localparam logic [2:0] CFG_SLOW_CUTOFF = 3'd4;
	localparam logic [2:0] CFG_FAST_CUTOFF = 3'd5;

	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_PULSE  = 1'b1;
	localparam logic WHEEL_FRONT = 1'b0;
	localparam logic WHEEL_REAR  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic        wheel;
		logic [15:0] pulse_period;
		logic        front_fault;
		logic        rear_fault;
	} in_word_t;

	typedef struct packed {
		logic [15:0] global_speed;
		logic        global_error;
		logic [15:0] front_speed;
		logic [15:0] rear_speed;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEL,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== sv/dual_wheel_speed_estimator.sv =====
// dual wheel speed estimator: period store, elapsed counters and a serial divider
// depends on dwse_pkg and dual_wheel_speed_estimator_assert.svh
// an item occupies the block through select, multiply, 25 divider steps, finish
// the result word is loaded into the output register in the finish step
// the divider is a 25-step restoring one; a stalled output holds the finish step
// arst_n resets the sequencer, config, periods, counters, speeds and out_valid
`default_nettype none
module dual_wheel_speed_estimator
	import dwse_pkg::*;
#(
	parameter int PERIOD_BITS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_word_t  in_word,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_word_t      out_word,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int P  = PERIOD_BITS;
	localparam int CW = (P > 16) ? P : 16;

	function automatic logic [P-1:0] advance(input logic [P-1:0] e, input logic [15:0] slow);
		logic [P:0] sum;
		sum = {1'b0, e} + (P+1)'(TICK_STEP);
		if (CW'(e) < CW'(slow))
			advance = sum[P] ? {P{1'b1}} : sum[P-1:0];
		else
			advance = e;
	endfunction

	state_t state_q, state_d;

	logic [7:0]  front_poles_q, rear_poles_q;
	logic [15:0] front_circ_q, rear_circ_q, slow_q, fast_q;

	logic [P-1:0] front_last_q, rear_last_q, front_elapsed_q, rear_elapsed_q;
	logic [15:0]  front_speed_q, rear_speed_q, comb_speed_q;
	logic         comb_error_q;

	logic          kind_q, wheel_q, ffault_q, rfault_q;
	logic          zero_q, use_rear_q, both_fault_q;
	logic [15:0]   pc_q;
	logic [7:0]    poles_q;
	logic [NUM_BITS-1:0] num_q;
	logic [DEN_BITS-1:0] den_q, rem_q;
	logic [CNT_BITS-1:0] cnt_q;

	logic      out_valid_q;
	out_word_t out_word_q;

	logic in_acc, done_load;

	// selection of wheel and operand
	logic         both_fault, use_rear;
	logic [P-1:0] sel_last, sel_elapsed, sel_p;
	logic [CW-1:0] pw;
	logic [7:0]   sel_poles;
	logic [15:0]  sel_circ, pc;
	logic         zero;

	always_comb begin
		both_fault  = (kind_q == KIND_TICK) && ffault_q && rfault_q;
		if (kind_q == KIND_PULSE)
			use_rear = (wheel_q == WHEEL_REAR);
		else if (!ffault_q && !rfault_q)
			use_rear = !(front_elapsed_q < rear_elapsed_q);
		else
			use_rear = ffault_q;
		sel_last    = use_rear ? rear_last_q : front_last_q;
		sel_elapsed = use_rear ? rear_elapsed_q : front_elapsed_q;
		sel_p       = (sel_last > sel_elapsed) ? sel_last : sel_elapsed;
		pw          = CW'(sel_p);
		sel_poles   = use_rear ? rear_poles_q : front_poles_q;
		sel_circ    = use_rear ? rear_circ_q : front_circ_q;
		zero = both_fault || (sel_p == '0) || (sel_poles == 8'd0) || (sel_circ == 16'd0) ||
			(pw > CW'(slow_q));
		pc = (pw < CW'(fast_q)) ? fast_q : pw[15:0];
	end

	// divider step
	logic [DEN_BITS:0] rem_sh, diff;
	logic              ge;

	always_comb begin
		rem_sh = {rem_q, num_q[NUM_BITS-1]};
		ge     = rem_sh >= {1'b0, den_q};
		diff   = rem_sh - {1'b0, den_q};
	end

	// finish values
	logic [15:0] spd, front_speed_d, rear_speed_d, comb_speed_d;
	logic        comb_error_d;

	always_comb begin
		if (zero_q)
			spd = 16'd0;
		else if (|num_q[NUM_BITS-1:16])
			spd = SPEED_MAX;
		else
			spd = num_q[15:0];
		front_speed_d = front_speed_q;
		rear_speed_d  = rear_speed_q;
		comb_speed_d  = comb_speed_q;
		comb_error_d  = comb_error_q;
		if (kind_q == KIND_PULSE) begin
			if (use_rear_q)
				rear_speed_d = spd;
			else
				front_speed_d = spd;
		end else begin
			comb_speed_d = spd;
			comb_error_d = both_fault_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		done_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					state_d = ST_SEL;
			end
			ST_SEL: state_d = ST_MUL;
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_BITS'(NUM_BITS - 1))
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					done_load = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// configuration and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_poles_q   <= 8'd0;
			front_circ_q    <= 16'd0;
			rear_poles_q    <= 8'd0;
			rear_circ_q     <= 16'd0;
			slow_q          <= SLOW_RESET;
			fast_q          <= FAST_RESET;
			front_last_q    <= P'(16'hFFFF);
			rear_last_q     <= P'(16'hFFFF);
			front_elapsed_q <= '0;
			rear_elapsed_q  <= '0;
			front_speed_q   <= 16'd0;
			rear_speed_q    <= 16'd0;
			comb_speed_q    <= 16'd0;
			comb_error_q    <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FRONT_POLES: front_poles_q <= cfg_data[7:0];
					CFG_FRONT_CIRC:  front_circ_q  <= cfg_data;
					CFG_REAR_POLES:  rear_poles_q  <= cfg_data[7:0];
					CFG_REAR_CIRC:   rear_circ_q   <= cfg_data;
					CFG_SLOW_CUTOFF: slow_q        <= cfg_data;
					CFG_FAST_CUTOFF: fast_q        <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				if (in_word.kind == KIND_PULSE) begin
					if (in_word.wheel == WHEEL_REAR) begin
						rear_last_q    <= P'(in_word.pulse_period);
						rear_elapsed_q <= '0;
					end else begin
						front_last_q    <= P'(in_word.pulse_period);
						front_elapsed_q <= '0;
					end
				end else begin
					front_elapsed_q <= advance(front_elapsed_q, slow_q);
					rear_elapsed_q  <= advance(rear_elapsed_q, slow_q);
				end
			end
			if (done_load) begin
				front_speed_q <= front_speed_d;
				rear_speed_q  <= rear_speed_d;
				comb_speed_q  <= comb_speed_d;
				comb_error_q  <= comb_error_d;
				out_valid_q   <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q   <= in_word.kind;
			wheel_q  <= in_word.wheel;
			ffault_q <= in_word.front_fault;
			rfault_q <= in_word.rear_fault;
		end
		case (state_q)
			ST_SEL: begin
				zero_q       <= zero;
				use_rear_q   <= use_rear;
				both_fault_q <= both_fault;
				pc_q         <= pc;
				poles_q      <= sel_poles;
				num_q        <= NUM_BITS'(sel_circ) * NUM_BITS'(SPEED_SCALE);
			end
			ST_MUL: begin
				den_q <= {8'd0, pc_q} * {16'd0, poles_q};
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
				num_q <= {num_q[NUM_BITS-2:0], ge};
				cnt_q <= cnt_q + CNT_BITS'(1);
			end
			default: ;
		endcase
		if (done_load) begin
			out_word_q.global_speed <= comb_speed_d;
			out_word_q.global_error <= comb_error_d;
			out_word_q.front_speed  <= front_speed_d;
			out_word_q.rear_speed   <= rear_speed_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

`include "dual_wheel_speed_estimator_assert.svh"

	`DWSE_ASSERT(a_div_count, (state_q == ST_DIV) |-> (cnt_q < CNT_BITS'(NUM_BITS)), "divider count overrun")
	`DWSE_ASSERT_NEXT(a_accept_sel, in_valid && !in_stall, state_q == ST_SEL, "accept did not start select")
	`DWSE_ASSERT(a_out_from_done, $rose(out_valid) |-> ($past(state_q) == ST_DONE), "word not from finish step")
	`DWSE_ASSERT(a_error_zero, (out_valid && out_word.global_error) |-> (out_word.global_speed == 16'd0), "error with nonzero speed")
	`DWSE_ASSERT_NEXT(a_div_end, (state_q == ST_DIV) && (cnt_q == CNT_BITS'(NUM_BITS - 1)), state_q == ST_DONE, "divider did not finish")

endmodule
`default_nettype wire

// ===== tb/sv/tb_dual_wheel_speed_estimator.sv =====
`timescale 1ns / 100ps
// testbench for dual_wheel_speed_estimator: directed and random pulse and tick words
// every output word is checked field by field against an in-bench speed model
// depends on dwse_pkg and the dual_wheel_speed_estimator rtl
module tb_dual_wheel_speed_estimator
	import dwse_pkg::*;
();

	localparam logic [15:0] PERIOD_TOP = 16'hFFFF;
	localparam int PHASES = 11;
	localparam int PHASE_WORDS = 150;

	typedef struct packed {
		logic [7:0]  front_poles;
		logic [15:0] front_circ;
		logic [7:0]  rear_poles;
		logic [15:0] rear_circ;
		logic [15:0] slow_cut;
		logic [15:0] fast_cut;
	} wheel_cfg_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_word_t    in_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_word_t   out_word;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// model of the block's registers and state
	wheel_cfg_t  cfg = '{8'd0, 16'd0, 8'd0, 16'd0, SLOW_RESET, FAST_RESET};
	logic [15:0] front_period = PERIOD_TOP;
	logic [15:0] rear_period = PERIOD_TOP;
	logic [15:0] front_elapsed = '0;
	logic [15:0] rear_elapsed = '0;
	logic [15:0] front_spd = '0;
	logic [15:0] rear_spd = '0;
	logic [15:0] glob_spd = '0;
	logic        glob_err = 1'b0;

	out_word_t due_speeds[$];
	bit calm = 1'b0;
	int error_count = 0;
	int words_checked = 0;
	int pulse_count = 0;
	int tick_count = 0;
	int reg_writes = 0;
	int settings = 0;

	dual_wheel_speed_estimator #(.PERIOD_BITS(16)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [15:0] wheel_speed_of(input logic [15:0] period,
			input logic [7:0] poles, input logic [15:0] circ);
		longint unsigned p;
		longint unsigned q;
		if (period == 0 || poles == 0 || circ == 0 || period > cfg.slow_cut)
			return '0;
		p = (period < cfg.fast_cut) ? 64'(cfg.fast_cut) : 64'(period);
		q = (64'(SPEED_SCALE) * 64'(circ)) / (p * 64'(poles));
		return (q > 64'(SPEED_MAX)) ? SPEED_MAX : q[15:0];
	endfunction

	function automatic logic [15:0] elapsed_after_tick(input logic [15:0] e);
		int unsigned s;
		if (e >= cfg.slow_cut)
			return e;
		s = e + TICK_STEP;
		return (s > 32'(PERIOD_TOP)) ? PERIOD_TOP : s[15:0];
	endfunction

	function automatic logic [15:0] derated_speed(input logic [15:0] last,
			input logic [15:0] elapsed, input logic [7:0] poles, input logic [15:0] circ);
		return wheel_speed_of((last > elapsed) ? last : elapsed, poles, circ);
	endfunction

	function automatic out_word_t speeds_after(input in_word_t w);
		out_word_t r;
		logic use_front;
		if (w.kind == KIND_PULSE) begin
			if (w.wheel == WHEEL_REAR) begin
				rear_period = w.pulse_period;
				rear_elapsed = '0;
				rear_spd = wheel_speed_of(w.pulse_period, cfg.rear_poles, cfg.rear_circ);
			end else begin
				front_period = w.pulse_period;
				front_elapsed = '0;
				front_spd = wheel_speed_of(w.pulse_period, cfg.front_poles, cfg.front_circ);
			end
		end else begin
			front_elapsed = elapsed_after_tick(front_elapsed);
			rear_elapsed = elapsed_after_tick(rear_elapsed);
			if (w.front_fault && w.rear_fault) begin
				glob_spd = '0;
				glob_err = 1'b1;
			end else begin
				// both healthy: front only when its elapsed count is strictly smaller
				if (!w.front_fault && !w.rear_fault)
					use_front = front_elapsed < rear_elapsed;
				else
					use_front = !w.front_fault;
				if (use_front)
					glob_spd = derated_speed(front_period, front_elapsed,
						cfg.front_poles, cfg.front_circ);
				else
					glob_spd = derated_speed(rear_period, rear_elapsed,
						cfg.rear_poles, cfg.rear_circ);
				glob_err = 1'b0;
			end
		end
		r.global_speed = glob_spd;
		r.global_error = glob_err;
		r.front_speed = front_spd;
		r.rear_speed = rear_spd;
		return r;
	endfunction

	function automatic in_word_t pulse_word(input logic wheel, input logic [15:0] period);
		in_word_t w;
		w.kind = KIND_PULSE;
		w.wheel = wheel;
		w.pulse_period = period;
		w.front_fault = 1'($urandom_range(1));
		w.rear_fault = 1'($urandom_range(1));
		return w;
	endfunction

	function automatic in_word_t tick_word(input logic ff, input logic rf);
		in_word_t w;
		w.kind = KIND_TICK;
		w.wheel = 1'($urandom_range(1));
		w.pulse_period = 16'($urandom_range(16'hFFFF));
		w.front_fault = ff;
		w.rear_fault = rf;
		return w;
	endfunction

	function automatic logic [15:0] rand_period();
		int v;
		case ($urandom_range(5))
		0: v = int'($urandom_range(16'hFFFF));
		1: v = int'($urandom_range(20));
		2: v = int'(cfg.slow_cut) + int'($urandom_range(6)) - 3;
		3: v = int'(cfg.fast_cut) + int'($urandom_range(6)) - 3;
		default: v = int'($urandom_range(cfg.slow_cut));
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	function automatic wheel_cfg_t pick_cfg(input int mode);
		wheel_cfg_t c;
		case (mode)
		0: c = '{8'd255, 16'hFFFF, 8'd255, 16'hFFFF, 16'd65435, 16'hFFFF};
		1: c = '0;
		2: begin
			c.front_poles = 8'($urandom_range(16));
			c.front_circ = 16'($urandom_range(3000));
			c.rear_poles = 8'($urandom_range(16));
			c.rear_circ = 16'($urandom_range(3000));
			c.slow_cut = 16'($urandom_range(30000));
			c.fast_cut = 16'($urandom_range(60));
		end
		3: begin
			c.front_poles = 8'($urandom_range(255));
			c.front_circ = 16'($urandom_range(16'hFFFF));
			c.rear_poles = 8'($urandom_range(255));
			c.rear_circ = 16'($urandom_range(16'hFFFF));
			c.slow_cut = 16'($urandom_range(65435));
			c.fast_cut = 16'($urandom_range(16'hFFFF));
		end
		default: begin
			c.front_poles = 8'($urandom_range(1, 8));
			c.front_circ = 16'($urandom_range(500, 3000));
			c.rear_poles = 8'($urandom_range(1, 8));
			c.rear_circ = 16'($urandom_range(500, 3000));
			c.slow_cut = 16'd65435;
			c.fast_cut = 16'd0;
		end
		endcase
		return c;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	task automatic send_item(input in_word_t w);
		if (!calm && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 36)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		due_speeds.push_back(speeds_after(w));
		if (w.kind == KIND_PULSE)
			pulse_count++;
		else
			tick_count++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (due_speeds.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
		CFG_FRONT_POLES: cfg.front_poles = data[7:0];
		CFG_FRONT_CIRC: cfg.front_circ = data;
		CFG_REAR_POLES: cfg.rear_poles = data[7:0];
		CFG_REAR_CIRC: cfg.rear_circ = data;
		CFG_SLOW_CUTOFF: cfg.slow_cut = data;
		CFG_FAST_CUTOFF: cfg.fast_cut = data;
		default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_config(input wheel_cfg_t c);
		wait_drained();
		// upper byte of the pole writes is junk the block must drop
		write_reg(CFG_FRONT_POLES, {8'($urandom), c.front_poles});
		write_reg(CFG_FRONT_CIRC, c.front_circ);
		write_reg(CFG_REAR_POLES, {8'($urandom), c.rear_poles});
		write_reg(CFG_REAR_CIRC, c.rear_circ);
		write_reg(CFG_SLOW_CUTOFF, c.slow_cut);
		write_reg(CFG_FAST_CUTOFF, c.fast_cut);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic test_reset_state();
		send_item(tick_word(1'b0, 1'b0));
		send_item(pulse_word(WHEEL_FRONT, 16'd100));
		send_item(pulse_word(WHEEL_REAR, 16'd100));
	endtask

	task automatic test_pulse_speed();
		set_config('{8'd2, 16'd2000, 8'd255, 16'hFFFF, 16'd20000, 16'd1});
		send_item(pulse_word(WHEEL_FRONT, 16'd0));
		send_item(pulse_word(WHEEL_FRONT, 16'd1));
		send_item(pulse_word(WHEEL_FRONT, 16'd20000));
		send_item(pulse_word(WHEEL_FRONT, 16'd20001));
		send_item(pulse_word(WHEEL_FRONT, PERIOD_TOP));
		send_item(pulse_word(WHEEL_REAR, 16'd1));
		send_item(pulse_word(WHEEL_REAR, PERIOD_TOP));
		send_item(pulse_word(WHEEL_REAR, 16'd3000));
	endtask

	task automatic test_tick_faults();
		send_item(tick_word(1'b0, 1'b0));
		send_item(tick_word(1'b0, 1'b1));
		send_item(tick_word(1'b1, 1'b0));
		send_item(tick_word(1'b1, 1'b1));
		send_item(tick_word(1'b0, 1'b0));
	endtask

	task automatic test_fast_clamp();
		wheel_cfg_t c;
		c = cfg;
		c.fast_cut = 16'd500;
		set_config(c);
		send_item(pulse_word(WHEEL_FRONT, 16'd10));
		send_item(pulse_word(WHEEL_REAR, 16'd0));
		send_item(tick_word(1'b0, 1'b1));
	endtask

	task automatic test_elapsed_cutoff();
		wheel_cfg_t c;
		c = cfg;
		c.slow_cut = 16'd300;
		c.fast_cut = 16'd1;
		set_config(c);
		send_item(pulse_word(WHEEL_FRONT, 16'd200));
		send_item(pulse_word(WHEEL_REAR, 16'd250));
		repeat (4)
			send_item(tick_word(1'b0, 1'b0));
	endtask

	task automatic test_random_traffic();
		int mode;
		int front_rate;
		int rear_rate;
		int fault_rate;
		int r;
		int rates[4] = '{0, 3, 25, 50};
		int faults[3] = '{0, 10, 40};
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase < 2)
				mode = phase;
			else if (phase == 2)
				mode = 4;
			else
				mode = $urandom_range(2, 3);
			set_config(pick_cfg(mode));
			calm = (phase == 5);
			front_rate = rates[$urandom_range(3)];
			rear_rate = rates[$urandom_range(3)];
			fault_rate = faults[$urandom_range(2)];
			for (int i = 0; i < PHASE_WORDS; i++) begin
				r = $urandom_range(99);
				if (r < front_rate)
					send_item(pulse_word(WHEEL_FRONT, rand_period()));
				else if (r < front_rate + rear_rate)
					send_item(pulse_word(WHEEL_REAR, rand_period()));
				else
					send_item(tick_word($urandom_range(99) < fault_rate,
						$urandom_range(99) < fault_rate));
			end
		end
		calm = 1'b0;
	endtask

	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < 12);

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_speeds.size() == 0) begin
				report_mismatch("word with nothing pending, global_speed",
					out_word.global_speed, 0);
			end else begin
				want = due_speeds.pop_front();
				words_checked++;
				if (out_word.global_speed !== want.global_speed)
					report_mismatch("global_speed", out_word.global_speed, want.global_speed);
				if (out_word.global_error !== want.global_error)
					report_mismatch("global_error", out_word.global_error, want.global_error);
				if (out_word.front_speed !== want.front_speed)
					report_mismatch("front_speed", out_word.front_speed, want.front_speed);
				if (out_word.rear_speed !== want.rear_speed)
					report_mismatch("rear_speed", out_word.rear_speed, want.rear_speed);
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_pulse_speed();
		test_tick_faults();
		test_fast_clamp();
		test_elapsed_cutoff();
		test_random_traffic();
		wait_drained();
		repeat (40) @(posedge clk);
		if (due_speeds.size() != 0)
			report_mismatch("words never delivered", due_speeds.size(), 0);
		$display("%0d words checked: %0d wheel pulses, %0d ticks", words_checked,
			pulse_count, tick_count);
		$display("%0d register writes over %0d settings", reg_writes, settings);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d words outstanding", due_speeds.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
